@@ sv/pointer_range_match_scan_macros.svh @@
// assertion macros for the pointer range match scan checker
`ifndef POINTER_RANGE_MATCH_SCAN_MACROS_SVH
`define POINTER_RANGE_MATCH_SCAN_MACROS_SVH

// property checked at every edge outside reset
`define PRMS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define PRMS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/prms_pkg.sv @@
// types and constants shared by the pointer range match scan modules
package prms_pkg;

   localparam int ADDR_W       = 48;
   localparam int INDEX_W      = 6;
   localparam int OFFSET_W     = 20;
   localparam int LIMIT_W      = 16;
   localparam int COUNT_W      = 7;
   localparam int WINDOW_DEPTH = 7;
   localparam int FILL_W       = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 20;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALIGN_CHECK  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_SPAN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESULT_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_COUNT = 3'd4;

   // request actions
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_BYTE = 1'b1;

   // canonical user pointer bounds
   localparam logic [63:0] USER_LOW   = 64'h0000_0000_0001_0000;
   localparam logic [63:0] USER_HIGH4 = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] USER_HIGH8 = 64'h0000_7FFF_FFFF_FFFF;

   // register reset values
   localparam logic [OFFSET_W-1:0] OFFSET_SPAN_RESET  = 20'd4096;
   localparam logic [LIMIT_W-1:0]  RESULT_LIMIT_RESET = 16'd65535;

   typedef struct packed {
      logic               action;
      logic [INDEX_W-1:0] entry_index;
      logic [ADDR_W-1:0]  entry_address;
      logic [7:0]         data_byte;
      logic [ADDR_W-1:0]  byte_address;
      logic               chain_break;
      logic               clear_count;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   storage_address;
      logic [INDEX_W-1:0]  entry_match;
      logic [OFFSET_W-1:0] pointer_offset;
      logic                limit_reached;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                width_mode;
      logic                align_check;
      logic [OFFSET_W-1:0] offset_span;
      logic [LIMIT_W-1:0]  result_limit;
      logic [COUNT_W-1:0]  target_count;
   } cfg_type;

   // pointer candidate handed from the window to the cells
   typedef struct packed {
      logic [ADDR_W-1:0] value;
      logic [ADDR_W-1:0] upper;
      logic [ADDR_W-1:0] start;
   } cand_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic              load_en;
      logic [ADDR_W-1:0] load_address;
      logic              compare_en;
      logic [ADDR_W-1:0] value;
      logic [ADDR_W-1:0] upper;
      logic              advance;
      logic              flush;
   } cell_bus_type;

   // neighbor link along the cell row
   typedef struct packed {
      logic prior;   // some lower cell still has a match pending
      logic multi;   // at least two lower cells have matches pending
   } chain_type;

endpackage

@@ sv/prms_cell.sv @@
// one target table entry with its range compare and pending match bit
module prms_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  prms_pkg::cell_bus_type            bus,
   input  logic                              load_sel,
   input  logic                              active,
   input  prms_pkg::chain_type               chain_in,
   output prms_pkg::chain_type               chain_out,
   output logic                              sel,
   output logic [prms_pkg::OFFSET_W-1:0]     offset_out
);

   logic [prms_pkg::ADDR_W-1:0] entry_ff;
   logic                        pending_ff;
   logic                        pending_in;
   logic                        in_range;

   assign in_range = (entry_ff >= bus.value) && (entry_ff <= bus.upper);
   assign sel      = pending_ff && !chain_in.prior;

   assign chain_out.prior = chain_in.prior | pending_ff;
   assign chain_out.multi = chain_in.multi | (chain_in.prior & pending_ff);

   // low bits of the difference are exact since the offset fits the field
   assign offset_out = sel ?
      (entry_ff[prms_pkg::OFFSET_W-1:0] - bus.value[prms_pkg::OFFSET_W-1:0]) : '0;

   always_comb begin
      pending_in = pending_ff;
      if (bus.compare_en) begin
         pending_in = active && in_range;
      end else if (bus.flush) begin
         pending_in = 1'b0;
      end else if (bus.advance && sel) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bus.load_en && load_sel) begin
         entry_ff <= bus.load_address;
      end
   end

endmodule

@@ sv/prms_window.sv @@
// byte window assembly and pointer candidate qualification
module prms_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  prms_pkg::req_type     req,
   input  prms_pkg::cfg_type     cfg,
   input  logic                  truncated,
   output logic                  cand_valid,
   output prms_pkg::cand_type    cand
);

   logic [7:0]                  win_ff [prms_pkg::WINDOW_DEPTH];
   logic [7:0]                  win_in [prms_pkg::WINDOW_DEPTH];
   logic [prms_pkg::FILL_W-1:0] fill_ff;
   logic [prms_pkg::FILL_W-1:0] fill_in;
   logic [prms_pkg::FILL_W-1:0] fill_eff;
   logic                        cand_valid_ff;
   logic                        cand_valid_in;
   prms_pkg::cand_type          cand_ff;
   prms_pkg::cand_type          cand_in;
   logic [63:0]                 value64;
   logic                        full;
   logic                        aligned_ok;
   logic                        canonical;

   assign fill_eff = req.chain_break ? '0 : fill_ff;
   assign full     = cfg.width_mode ? (fill_eff == 3'd7) : (fill_eff >= 3'd3);

   // newest byte is the most significant one
   assign value64 = cfg.width_mode ?
      {req.data_byte, win_ff[0], win_ff[1], win_ff[2], win_ff[3], win_ff[4], win_ff[5],
       win_ff[6]} :
      {32'd0, req.data_byte, win_ff[0], win_ff[1], win_ff[2]};

   always_comb begin
      cand_in.value = value64[prms_pkg::ADDR_W-1:0];
      cand_in.start = req.byte_address - (cfg.width_mode ? 48'd7 : 48'd3);
      cand_in.upper = value64[prms_pkg::ADDR_W-1:0] + 48'(cfg.offset_span);
   end

   assign aligned_ok = !cfg.align_check ||
      (cfg.width_mode ? (cand_in.start[2:0] == 3'd0) : (cand_in.start[1:0] == 2'd0));
   assign canonical = (value64 >= prms_pkg::USER_LOW) &&
      (value64 <= (cfg.width_mode ? prms_pkg::USER_HIGH8 : prms_pkg::USER_HIGH4));

   assign cand_valid_in = take && full && !truncated && aligned_ok && canonical;

   always_comb begin
      win_in[0] = req.data_byte;
      for (int k = 1; k < prms_pkg::WINDOW_DEPTH; k++) begin
         win_in[k] = win_ff[k-1];
      end
      fill_in = fill_ff;
      if (take) begin
         fill_in = (fill_eff == 3'd7) ? 3'd7 : fill_eff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         cand_valid_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         cand_valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         win_ff  <= win_in;
         cand_ff <= cand_in;
      end
   end

   assign cand_valid = cand_valid_ff;
   assign cand       = cand_ff;

endmodule

@@ sv/pointer_range_match_scan.sv @@
// top level of the pointer range match scan: csr, cell row and result register
//
//  channel | direction | handshake          | carries
//  req     | in        | req_valid/req_stall | table load or one memory byte
//  rsp     | out       | rsp_valid/rsp_stall | one pointer match
//  csr     | in        | csr_valid/csr_ready | register index and write data
//
// a load request or a byte that forms no usable pointer does not stall the request port
// a byte that forms a usable pointer stalls it through the window register and the cell compare,
// then while the single result register drains the row one match at a time
// rsp_stall holds the result register; the row waits while it is full and stalled
// synchronous reset clears control state; table entries stay undefined until loaded
module pointer_range_match_scan #(
   parameter int TARGET_ENTRIES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  prms_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output prms_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prms_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [prms_pkg::CSR_DATA_W-1:0]      csr_data
);

   // configuration registers
   prms_pkg::cfg_type cfg_ff;
   prms_pkg::cfg_type cfg_in;

   // match bookkeeping
   logic [prms_pkg::LIMIT_W-1:0] match_count_ff;
   logic [prms_pkg::LIMIT_W-1:0] match_count_in;
   logic [prms_pkg::LIMIT_W-1:0] count_inc;
   logic                         truncated_ff;
   logic                         truncated_in;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   prms_pkg::rsp_type rsp_ff;
   prms_pkg::rsp_type rsp_in;

   logic               req_take;
   logic               byte_take;
   logic               load_take;
   logic               csr_take;
   logic               cand_valid;
   prms_pkg::cand_type cand;
   logic               any_pending;
   logic               emit;
   logic               hit;

   prms_pkg::cell_bus_type        bus;
   prms_pkg::chain_type           chain [TARGET_ENTRIES+1];
   logic [TARGET_ENTRIES-1:0]     cell_sel;
   logic [prms_pkg::OFFSET_W-1:0] cell_offset [TARGET_ENTRIES];
   logic [prms_pkg::INDEX_W-1:0]  match_index;
   logic [prms_pkg::OFFSET_W-1:0] match_offset;

   // writes are to arrive only while the block is idle, which the block does not enforce; the port never waits
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   // one request at a time while a candidate is compared or matches drain
   assign req_stall = cand_valid || any_pending;
   assign req_take  = req_valid && !req_stall;
   assign byte_take = req_take && (req_data.action == prms_pkg::ACTION_BYTE);
   assign load_take = req_take && (req_data.action == prms_pkg::ACTION_LOAD);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         unique case (csr_index)
            prms_pkg::CSR_WIDTH_MODE:   cfg_in.width_mode   = csr_data[0];
            prms_pkg::CSR_ALIGN_CHECK:  cfg_in.align_check  = csr_data[0];
            prms_pkg::CSR_OFFSET_SPAN:  cfg_in.offset_span  = csr_data[prms_pkg::OFFSET_W-1:0];
            prms_pkg::CSR_RESULT_LIMIT: cfg_in.result_limit = csr_data[prms_pkg::LIMIT_W-1:0];
            prms_pkg::CSR_TARGET_COUNT: cfg_in.target_count = csr_data[prms_pkg::COUNT_W-1:0];
            default: begin
               // unknown index: write is dropped
            end
         endcase
      end
   end

   // window front end: shifts every byte, flags canonical pointer candidates
   prms_window u_window (
      .clock      (clock),
      .reset      (reset),
      .take       (byte_take),
      .req        (req_data),
      .cfg        (cfg_ff),
      .truncated  (truncated_ff),
      .cand_valid (cand_valid),
      .cand       (cand)
   );

   // broadcast to the cell row
   always_comb begin
      bus.load_en      = load_take;
      bus.load_address = req_data.entry_address;
      bus.compare_en   = cand_valid;
      bus.value        = cand.value;
      bus.upper        = cand.upper;
      bus.advance      = emit;
      bus.flush        = emit && hit;
   end

   // one cell per table entry; the lowest pending cell owns the next result
   assign chain[0] = '0;

   for (genvar i = 0; i < TARGET_ENTRIES; i++) begin : g_cell
      prms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bus        (bus),
         .load_sel   (req_data.entry_index == prms_pkg::INDEX_W'(i)),
         .active     (cfg_ff.target_count > prms_pkg::COUNT_W'(i)),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .sel        (cell_sel[i]),
         .offset_out (cell_offset[i])
      );
   end

   assign any_pending = chain[TARGET_ENTRIES].prior;

   // at most one cell selects, so the fields combine by or
   always_comb begin
      match_index  = '0;
      match_offset = '0;
      for (int i = 0; i < TARGET_ENTRIES; i++) begin
         if (cell_sel[i]) begin
            match_index = match_index | prms_pkg::INDEX_W'(i);
         end
         match_offset = match_offset | cell_offset[i];
      end
   end

   // a match moves into the result register when it is empty or being taken
   assign emit      = any_pending && (!rsp_valid_ff || !rsp_stall);
   assign count_inc = match_count_ff + 16'd1;
   // a zero limit is met by the first match
   assign hit       = count_inc >= cfg_ff.result_limit;

   always_comb begin
      match_count_in = match_count_ff;
      truncated_in   = truncated_ff;
      if (load_take && req_data.clear_count) begin
         match_count_in = '0;
         truncated_in   = 1'b0;
      end else if (emit) begin
         match_count_in = count_inc;
         if (hit) begin
            truncated_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_in.storage_address = cand.start;
         rsp_in.entry_match     = match_index;
         rsp_in.pointer_offset  = match_offset;
         rsp_in.limit_reached   = hit;
         // last when no other cell is pending or the limit cuts the burst
         rsp_in.last            = hit || !chain[TARGET_ENTRIES].multi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_mode   <= 1'b1;
         cfg_ff.align_check  <= 1'b1;
         cfg_ff.offset_span  <= prms_pkg::OFFSET_SPAN_RESET;
         cfg_ff.result_limit <= prms_pkg::RESULT_LIMIT_RESET;
         cfg_ff.target_count <= '0;
         match_count_ff      <= '0;
         truncated_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         match_count_ff <= match_count_in;
         truncated_ff   <= truncated_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/prms_checker.sv @@
// port level checks for the pointer range match scan, bound to the top level
`include "pointer_range_match_scan_macros.svh"

module prms_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input prms_pkg::req_type                 req_data,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input prms_pkg::rsp_type                 rsp_data,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [prms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [prms_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [prms_pkg::OFFSET_W-1:0] span_ff;
   logic [prms_pkg::OFFSET_W-1:0] span_in;

   always_comb begin
      span_in = span_ff;
      if (csr_valid && csr_ready && (csr_index == prms_pkg::CSR_OFFSET_SPAN)) begin
         span_in = csr_data[prms_pkg::OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= prms_pkg::OFFSET_SPAN_RESET;
      end else begin
         span_ff <= span_in;
      end
   end

   `PRMS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "held result changed")
   `PRMS_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable(req_data), "held request changed")
   `PRMS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")
   `PRMS_ASSERT(a_offset_range, rsp_valid |-> rsp_data.pointer_offset <= span_ff, "offset beyond span")
   `PRMS_ASSERT(a_limit_last, rsp_valid && rsp_data.limit_reached |-> rsp_data.last, "limit without last")

endmodule

bind pointer_range_match_scan prms_checker u_prms_checker (.*);
